@@ hw/rtl/sha256_pkg.sv @@
// Shared types, round constants and sigma functions for the SHA-256 digest block.
`timescale 1ns / 1ps

package sha256_pkg;

	typedef logic [15:0][31:0] blk_t;
	typedef logic [7:0][31:0] hash_t;

	typedef struct packed {
		logic start;
		logic init;
	} cmp_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [63:0] BITS_PER_BYTE = 64'd8;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] iv_const(input logic [2:0] i);
		logic [31:0] r;
		case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] k_const(input logic [5:0] i);
		logic [31:0] r;
		case (i)
			6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
			6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
			6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
			6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
			6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
			6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
			6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
			6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
			6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
			6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
			6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
			6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
			6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
			6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
			6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
			6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
			6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
			6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
			6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
			6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
			6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
			6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
			6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
			6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
			6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
			6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
			6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
			6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
			6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
			6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
			6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
			6'd62: r = 32'hbef9a3f7;
			default: r = 32'hc67178f2;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/sha256_stream_if.sv @@
// Valid/ready stream interfaces for message bytes in and digest words out.
`timescale 1ns / 1ps

interface sha256_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source (output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ hw/rtl/sha256_compress.sv @@
// Iterative SHA-256 compression: one round per cycle with a rolling message schedule.
`timescale 1ns / 1ps

module sha256_compress (
	input  logic                clk,
	input  logic                arst_n,
	input  sha256_pkg::cmp_ctl_t ctl,
	input  sha256_pkg::blk_t    blk,
	output logic                done,
	output sha256_pkg::hash_t   chain
);

	sha256_pkg::hash_t chain_q;
	sha256_pkg::hash_t var_q;
	sha256_pkg::blk_t  win_q;
	logic [5:0]        rnd_q;
	logic              busy_q;
	logic              fin_q;

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;

	always_comb begin
		ch    = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		maj   = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
		t1    = var_q[7] + sha256_pkg::bsig1(var_q[4]) + ch + sha256_pkg::k_const(rnd_q)
			+ win_q[0];
		t2    = sha256_pkg::bsig0(var_q[0]) + maj;
		w_new = sha256_pkg::ssig1(win_q[14]) + win_q[9] + sha256_pkg::ssig0(win_q[1])
			+ win_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			rnd_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= sha256_pkg::iv_const(3'(i));
			end
		end else begin
			fin_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (&rnd_q) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
			if (ctl.init) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= sha256_pkg::iv_const(3'(i));
				end
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					chain_q[i] <= chain_q[i] + var_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			var_q <= chain_q;
			win_q <= blk;
		end else if (busy_q) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
			win_q    <= {w_new, win_q[15:1]};
		end
	end

	assign done  = fin_q;
	assign chain = chain_q;

endmodule

@@ hw/rtl/sha256_message_digest.sv @@
// Top level of the streaming SHA-256 digest block: byte packing, padding and digest output.
// The msg channel takes one item per handshake: an optional message byte and an
// end-of-message flag. The digest channel returns eight 32-bit words, most
// significant first, with word_index 0 to 7 and last_word set on the eighth.
// An item that completes no 64-byte block and ends no message is taken and the
// block stays ready. An item that fills a block starts the compression, which
// runs one round per cycle on a single shared round unit: the block is not
// ready again until that compression is done. An end-of-message item adds a
// padding step and one or two compressions (two when eight or fewer byte slots
// remain in the block, with a step between them to load the length block),
// after which the digest words are offered one per cycle while the receiver
// keeps taking them. The digest channel holds each word until it is taken;
// while the receiver stalls, the block waits and takes no new word. After the
// last word is taken the chaining hash, bit count and byte position return
// to their initial values, ready for the next message. Reset is asynchronous
// and leaves the block idle and ready with the initial hash loaded; the block
// buffer needs no clearing.
`timescale 1ns / 1ps

module sha256_message_digest (
	input  logic                clk,
	input  logic                arst_n,
	sha256_in_if.sink           msg,
	sha256_out_if.source        digest
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PAD  = 3'd1;
	localparam logic [2:0] S_KICK = 3'd2;
	localparam logic [2:0] S_COMP = 3'd3;
	localparam logic [2:0] S_ZERO = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	localparam logic [1:0] AFT_IDLE = 2'd0;
	localparam logic [1:0] AFT_PAD  = 2'd1;
	localparam logic [1:0] AFT_ZERO = 2'd2;
	localparam logic [1:0] AFT_EMIT = 2'd3;

	logic [2:0]           state_q;
	logic [1:0]           after_q;
	logic [5:0]           pos_q;
	logic [63:0]          len_q;
	logic [2:0]           idx_q;
	sha256_pkg::blk_t     blk_q;
	sha256_pkg::blk_t     blk_pad;
	sha256_pkg::blk_t     blk_zero;
	sha256_pkg::hash_t    chain;
	sha256_pkg::cmp_ctl_t ctl;
	logic                 cmp_done;
	logic                 msg_acc;
	logic                 dig_acc;

	assign msg.ready   = (state_q == S_IDLE);
	assign msg_acc     = msg.valid && msg.ready;
	assign digest.valid = (state_q == S_EMIT);
	assign dig_acc     = digest.valid && digest.ready;

	assign digest.digest_word = chain[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = &idx_q;

	assign ctl.start = (state_q == S_KICK);
	assign ctl.init  = dig_acc && (&idx_q);

	always_comb begin
		logic [5:0] bp;
		bp = '0;
		blk_pad = blk_q;
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				bp = 6'(w * 4 + b);
				if (bp == pos_q) begin
					blk_pad[w][8 * (3 - b) +: 8] = sha256_pkg::PAD_BYTE;
				end else if (bp > pos_q) begin
					blk_pad[w][8 * (3 - b) +: 8] = 8'h00;
				end
			end
		end
		if (!(&pos_q[5:3])) begin
			blk_pad[14] = len_q[63:32];
			blk_pad[15] = len_q[31:0];
		end
		blk_zero     = '0;
		blk_zero[14] = len_q[63:32];
		blk_zero[15] = len_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= AFT_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						if (msg.has_byte) begin
							len_q <= len_q + sha256_pkg::BITS_PER_BYTE;
							pos_q <= pos_q + 6'd1;
							if (&pos_q) begin
								state_q <= S_KICK;
								after_q <= msg.end_of_message ? AFT_PAD : AFT_IDLE;
							end else if (msg.end_of_message) begin
								state_q <= S_PAD;
							end
						end else if (msg.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					state_q <= S_KICK;
					after_q <= (&pos_q[5:3]) ? AFT_ZERO : AFT_EMIT;
				end
				S_KICK: begin
					state_q <= S_COMP;
				end
				S_COMP: begin
					if (cmp_done) begin
						case (after_q)
							AFT_IDLE: state_q <= S_IDLE;
							AFT_PAD:  state_q <= S_PAD;
							AFT_ZERO: state_q <= S_ZERO;
							AFT_EMIT: begin
								state_q <= S_EMIT;
								idx_q   <= '0;
							end
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_ZERO: begin
					state_q <= S_KICK;
					after_q <= AFT_EMIT;
				end
				S_EMIT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 3'd1;
						if (&idx_q) begin
							state_q <= S_IDLE;
							pos_q   <= '0;
							len_q   <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (msg_acc && msg.has_byte) begin
			blk_q[pos_q[5:2]][{~pos_q[1:0], 3'b000} +: 8] <= msg.data_byte;
		end else if (state_q == S_PAD) begin
			blk_q <= blk_pad;
		end else if (state_q == S_ZERO) begin
			blk_q <= blk_zero;
		end
	end

	sha256_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk_q),
		.done   (cmp_done),
		.chain  (chain)
	);

endmodule

@@ hw/rtl/sha256_check.sv @@
// Port-level checker for the SHA-256 digest block and its bind to the top level.
`timescale 1ns / 1ps

module sha256_check (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] word_index,
	input logic       last_word
);

	a_no_input_while_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while digest words are pending");

	a_last_flag_matches_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match word_index");

	a_next_word_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=>
			(out_valid && (word_index == $past(word_index) + 3'd1)))
		else $error("digest word sequence broken");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_word) |=> (!out_valid && in_ready))
		else $error("block not idle after the last digest word");

endmodule

bind sha256_message_digest sha256_check u_check (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (msg.ready),
	.out_valid  (digest.valid),
	.out_ready  (digest.ready),
	.word_index (digest.word_index),
	.last_word  (digest.last_word)
);
